@@ hdl/sacfr_pkg.sv @@
// shared types and constants for the sum and add checked frame receiver
package sacfr_pkg;

	// store size default
	localparam int MaxPayloadDef = 32;

	// framing constants
	localparam logic [7:0] START_BYTE = 8'hAA;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SUM  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// stream widths
	localparam int OutDataW = 40;
	localparam int OutUserW = 3;

	// finished frame record passed from front to back
	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] func;
		logic [7:0] len;
		logic [1:0] status;
		logic       bank;
	} frame_desc_t;

	// payload store write request
	typedef struct packed {
		logic       we;
		logic       bank;
		logic [7:0] idx;
		logic [7:0] data;
	} store_wr_t;

endpackage

@@ hdl/sacfr_front.sv @@
// front parser: hunts for start byte, checks sums, writes payload, queues frame records
module sacfr_front import sacfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MaxPayloadDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        q_full,
	output logic        q_push,
	output frame_desc_t q_desc,
	output store_wr_t   st_wr
);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_DEST   = 3'd1;
	localparam logic [2:0] PH_FUNC   = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_SUMCHK = 3'd5;
	localparam logic [2:0] PH_ADDCHK = 3'd6;

	localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);

	logic [2:0] phase_q;
	logic [7:0] byte_count_q;
	logic [7:0] len_q;
	logic [7:0] dest_q;
	logic [7:0] func_q;
	logic [7:0] run_sum_q;
	logic [7:0] run_add_q;
	logic [7:0] rcv_sum_q;
	logic       wbank_q;

	logic       acc;
	logic [7:0] sum_nxt;
	logic [7:0] add_nxt;
	logic [7:0] cnt_nxt;
	logic [1:0] chk_status;

	// stall only while two finished frames are waiting
	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// running sum and sum of sums
	assign sum_nxt = (phase_q == PH_HUNT) ? rx_byte : run_sum_q + rx_byte;
	assign add_nxt = (phase_q == PH_HUNT) ? rx_byte : run_add_q + sum_nxt;
	assign cnt_nxt = byte_count_q + 8'd1;

	// frame verdict on the add check byte
	always_comb begin
		if (rcv_sum_q != run_sum_q || rx_byte != run_add_q) begin
			chk_status = ST_BAD_SUM;
		end else if ({1'b0, len_q} > MaxLen) begin
			chk_status = ST_TOO_LONG;
		end else begin
			chk_status = ST_OK;
		end
	end

	// frame record and store write
	assign q_push = acc && (phase_q == PH_ADDCHK);
	always_comb begin
		q_desc.dest   = dest_q;
		q_desc.func   = func_q;
		q_desc.len    = len_q;
		q_desc.status = chk_status;
		q_desc.bank   = wbank_q;
	end

	always_comb begin
		st_wr.we   = acc && (phase_q == PH_DATA) && ({1'b0, byte_count_q} < MaxLen);
		st_wr.bank = wbank_q;
		st_wr.idx  = byte_count_q;
		st_wr.data = rx_byte;
	end

	// phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			byte_count_q <= '0;
			len_q        <= '0;
			dest_q       <= '0;
			func_q       <= '0;
			run_sum_q    <= '0;
			run_add_q    <= '0;
			rcv_sum_q    <= '0;
			wbank_q      <= 1'b0;
		end else if (acc) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						run_sum_q <= sum_nxt;
						run_add_q <= add_nxt;
						phase_q   <= PH_DEST;
					end
				end
				PH_DEST: begin
					dest_q    <= rx_byte;
					run_sum_q <= sum_nxt;
					run_add_q <= add_nxt;
					phase_q   <= PH_FUNC;
				end
				PH_FUNC: begin
					func_q    <= rx_byte;
					run_sum_q <= sum_nxt;
					run_add_q <= add_nxt;
					phase_q   <= PH_LEN;
				end
				PH_LEN: begin
					len_q        <= rx_byte;
					byte_count_q <= '0;
					run_sum_q    <= sum_nxt;
					run_add_q    <= add_nxt;
					phase_q      <= (rx_byte == 8'd0) ? PH_SUMCHK : PH_DATA;
				end
				PH_DATA: begin
					run_sum_q    <= sum_nxt;
					run_add_q    <= add_nxt;
					byte_count_q <= cnt_nxt;
					if (cnt_nxt >= len_q) begin
						phase_q <= PH_SUMCHK;
					end
				end
				PH_SUMCHK: begin
					rcv_sum_q <= rx_byte;
					phase_q   <= PH_ADDCHK;
				end
				PH_ADDCHK: begin
					phase_q <= PH_HUNT;
					// a good frame with data keeps its bank until drained
					if (chk_status == ST_OK && len_q != 8'd0) begin
						wbank_q <= !wbank_q;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

@@ hdl/sacfr_queue.sv @@
// two-entry queue of finished frame records between front and back
module sacfr_queue import sacfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output frame_desc_t head_desc
);

	frame_desc_t ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// no overflow, no underflow, pointers agree with count
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

@@ hdl/sacfr_back.sv @@
// back end: payload store and result sequencer feeding the output register
module sacfr_back import sacfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MaxPayloadDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  store_wr_t   st_wr,
	input  logic        head_valid,
	input  frame_desc_t head_desc,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  dest_addr,
	output logic [7:0]  func_id,
	output logic [7:0]  frame_length,
	output logic [4:0]  byte_index,
	output logic [7:0]  payload_byte,
	output logic        has_byte,
	output logic [1:0]  status,
	output logic        last
);

	localparam int IdxW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int Depth = 2 * (1 << IdxW);

	// two banks of payload bytes
	logic [7:0] mem [Depth];

	logic [IdxW-1:0] rd_idx_q;
	logic            issue;
	logic            data_kind;
	logic            item_last;

	logic            pend_s1;
	logic [7:0]      rdata_s1;
	frame_desc_t     desc_s1;
	logic [IdxW-1:0] idx_s1;
	logic            has_s1;
	logic            last_s1;

	logic            out_valid_q;

	// a frame with data only when checks passed and length is nonzero
	assign data_kind = (head_desc.status == ST_OK) && (head_desc.len != 8'd0);
	assign item_last = !data_kind || ((8'(rd_idx_q) + 8'd1) == head_desc.len);
	assign issue     = head_valid && !pend_s1 && (!out_valid_q || out_ready);
	assign pop       = issue && item_last;

	// store write from front, registered read for back
	always_ff @(posedge clk) begin
		if (st_wr.we) begin
			mem[{st_wr.bank, st_wr.idx[IdxW-1:0]}] <= st_wr.data;
		end
		rdata_s1 <= mem[{head_desc.bank, rd_idx_q}];
	end

	// item metadata alongside the store read
	always_ff @(posedge clk) begin
		if (issue) begin
			desc_s1 <= head_desc;
			idx_s1  <= rd_idx_q;
			has_s1  <= data_kind;
			last_s1 <= item_last;
		end
	end

	// read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				rd_idx_q <= item_last ? '0 : rd_idx_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			dest_addr    <= desc_s1.dest;
			func_id      <= desc_s1.func;
			frame_length <= desc_s1.len;
			byte_index   <= has_s1 ? 5'(idx_s1) : 5'd0;
			payload_byte <= has_s1 ? rdata_s1 : 8'd0;
			has_byte     <= has_s1;
			status       <= desc_s1.status;
			last         <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

	// loading never overwrites an unaccepted result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q) else $error("result overwritten");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> !issue) else $error("back issued twice in a row");
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status != ST_OK) |-> (last && !has_byte))
		else $error("error result not single");

endmodule

@@ hdl/sum_add_checked_frame_receiver.sv @@
// top level of the sum and add checked frame receiver
// Takes one received serial byte per request on s_axis and emits decoded frames on m_axis.
// The front parser accepts a byte every cycle; it holds s_axis_tready low only while two
// finished frames wait for the back end. Each good frame comes out as one result per payload
// byte (last marked), a zero-length frame as one empty result, and a frame with a bad check
// or a length above MAX_PAYLOAD as one status result. The back end starts the next result
// only once the previous one has left the registered read of the double-banked payload store
// for the output register. There is no clearing pass after reset.
module sum_add_checked_frame_receiver import sacfr_pkg::*; #(
	parameter int MAX_PAYLOAD = MaxPayloadDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // rx_byte[7:0]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// dest_addr[7:0], func_id[15:8], frame_length[23:16], byte_index[28:24],
	// payload_byte[36:29], zero fill[39:37]
	output logic [OutDataW-1:0] m_axis_tdata,
	output logic [OutUserW-1:0] m_axis_tuser,   // has_byte[0], status[2:1]
	output logic                m_axis_tlast
);

	logic        q_full;
	logic        q_push;
	frame_desc_t q_desc;
	logic        q_pop;
	logic        head_valid;
	frame_desc_t head_desc;
	store_wr_t   st_wr;

	logic [7:0] dest_addr;
	logic [7:0] func_id;
	logic [7:0] frame_length;
	logic [4:0] byte_index;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic [1:0] status;

	sacfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.rx_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (q_desc),
		.st_wr    (st_wr)
	);

	sacfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_desc),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	sacfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.st_wr        (st_wr),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.dest_addr    (dest_addr),
		.func_id      (func_id),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.status       (status),
		.last         (m_axis_tlast)
	);

	// pack result fields
	assign m_axis_tdata = {3'b000, payload_byte, byte_index, frame_length, func_id, dest_addr};
	assign m_axis_tuser = {status, has_byte};

endmodule

@@ dv/sum_add_checked_frame_receiver_test.sv @@
// testbench for the sum and add checked frame receiver: predicted results against the stream output
`timescale 1ns / 100ps

module sum_add_checked_frame_receiver_test import sacfr_pkg::*; ();

	localparam int StoreDepth = MaxPayloadDef;

	// one decoded result as it leaves m_axis
	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] func;
		logic [7:0] len;
		logic [4:0] idx;
		logic [7:0] data;
		logic       has;
		logic [1:0] status;
		logic       last_item;
	} frame_item_t;

	typedef enum logic [2:0] {
		RX_HUNT, RX_DEST, RX_FUNC, RX_LEN, RX_DATA, RX_SUM_CHK, RX_ADD_CHK
	} rx_phase_e;

	// check byte damage kinds for generated frames
	localparam logic [1:0] DMG_NONE = 2'd0;
	localparam logic [1:0] DMG_SUM  = 2'd1;
	localparam logic [1:0] DMG_ADD  = 2'd2;
	localparam logic [1:0] DMG_BOTH = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = 8'h00;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic [OutUserW-1:0] m_axis_tuser;
	logic                m_axis_tlast;

	sum_add_checked_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// mirror of the parser state
	rx_phase_e   rx_phase = RX_HUNT;
	logic [7:0]  rx_count = '0;
	logic [7:0]  rx_len = '0;
	logic [7:0]  rx_dest = '0;
	logic [7:0]  rx_func = '0;
	logic [7:0]  rx_sum = '0;
	logic [7:0]  rx_add = '0;
	logic [7:0]  rx_sum_got = '0;
	logic [7:0]  rx_store [StoreDepth];

	frame_item_t frames_due[$];
	bit          calm = 1'b0;
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          results_due_total = 0;
	int          results_checked = 0;
	int          good_frames = 0;
	int          bad_frames = 0;
	int          long_frames = 0;

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	function automatic void post_item(input logic [4:0] idx, input logic [7:0] data,
			input logic has, input logic [1:0] status, input logic last_item);
		frame_item_t it;
		it.dest      = rx_dest;
		it.func      = rx_func;
		it.len       = rx_len;
		it.idx       = idx;
		it.data      = data;
		it.has       = has;
		it.status    = status;
		it.last_item = last_item;
		frames_due.push_back(it);
		results_due_total++;
	endfunction

	function automatic void fold_in(input logic [7:0] b);
		rx_sum = rx_sum + b;
		rx_add = rx_add + rx_sum;
	endfunction

	// predict what one accepted rx byte produces
	function automatic void parse_rx_byte(input logic [7:0] b);
		int i;
		case (rx_phase)
			RX_HUNT: begin
				if (b == START_BYTE) begin
					rx_sum = '0;
					rx_add = '0;
					fold_in(b);
					rx_phase = RX_DEST;
				end
			end
			RX_DEST: begin
				rx_dest = b;
				fold_in(b);
				rx_phase = RX_FUNC;
			end
			RX_FUNC: begin
				rx_func = b;
				fold_in(b);
				rx_phase = RX_LEN;
			end
			RX_LEN: begin
				rx_len = b;
				rx_count = '0;
				fold_in(b);
				rx_phase = (b == 8'd0) ? RX_SUM_CHK : RX_DATA;
			end
			RX_DATA: begin
				if (rx_count < StoreDepth)
					rx_store[rx_count] = b;
				fold_in(b);
				rx_count = rx_count + 8'd1;
				if (rx_count >= rx_len)
					rx_phase = RX_SUM_CHK;
			end
			RX_SUM_CHK: begin
				rx_sum_got = b;
				rx_phase = RX_ADD_CHK;
			end
			default: begin
				rx_phase = RX_HUNT;
				if (rx_sum_got != rx_sum || b != rx_add) begin
					post_item('0, '0, 1'b0, ST_BAD_SUM, 1'b1);
					bad_frames++;
				end else if (rx_len > StoreDepth) begin
					post_item('0, '0, 1'b0, ST_TOO_LONG, 1'b1);
					long_frames++;
				end else if (rx_len == 8'd0) begin
					post_item('0, '0, 1'b0, ST_OK, 1'b1);
					good_frames++;
				end else begin
					for (i = 0; i < rx_len && i < StoreDepth; i++)
						post_item(i[4:0], rx_store[i], 1'b1, ST_OK, (i + 1 == rx_len));
					good_frames++;
				end
			end
		endcase
	endfunction

	// send one byte request, with random idle cycles in front
	task automatic send_rx_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		parse_rx_byte(b);
	endtask

	// build a frame with proper checks, optionally damage them or cut it short
	task automatic send_frame(input logic [7:0] dest, input logic [7:0] func,
			input logic [7:0] len, input logic [1:0] damage, input int fill = -1,
			input int keep = -1);
		logic [7:0] bytes[$];
		logic [7:0] s;
		logic [7:0] a;
		int         i;
		bytes = {START_BYTE, dest, func, len};
		for (i = 0; i < len; i++)
			bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
		s = '0;
		a = '0;
		foreach (bytes[k]) begin
			s = s + bytes[k];
			a = a + s;
		end
		if (damage == DMG_SUM || damage == DMG_BOTH)
			s = s ^ 8'($urandom_range(1, 255));
		if (damage == DMG_ADD || damage == DMG_BOTH)
			a = a ^ 8'($urandom_range(1, 255));
		bytes.push_back(s);
		bytes.push_back(a);
		foreach (bytes[k])
			if (keep < 0 || k < keep)
				send_rx_byte(bytes[k]);
	endtask

	// drop valid and hold off until every predicted result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (frames_due.size() != 0);
	endtask

	// result side: random back pressure and comparison against the oldest prediction
	always @(posedge clk) begin
		frame_item_t got;
		frame_item_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.dest      = m_axis_tdata[7:0];
				got.func      = m_axis_tdata[15:8];
				got.len       = m_axis_tdata[23:16];
				got.idx       = m_axis_tdata[28:24];
				got.data      = m_axis_tdata[36:29];
				got.has       = m_axis_tuser[0];
				got.status    = m_axis_tuser[2:1];
				got.last_item = m_axis_tlast;
				if (frames_due.size() == 0) begin
					note_failure($sformatf("unexpected result %p", got));
				end else begin
					want = frames_due.pop_front();
					results_checked++;
					if (got !== want)
						note_failure($sformatf("expected %p got %p", want, got));
				end
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 16);
		end
	end

	// bytes outside a frame are ignored
	task automatic test_hunt_noise();
		send_rx_byte(8'h00);
		send_rx_byte(8'hFF);
		send_rx_byte(8'h55);
		send_rx_byte(8'h7F);
	endtask

	// zero length frame goes straight to its check bytes
	task automatic test_empty_frame();
		send_frame(8'h00, 8'hFF, 8'd0, DMG_NONE);
	endtask

	// one payload byte with extreme header values
	task automatic test_single_byte();
		send_frame(8'hFF, 8'h00, 8'd1, DMG_NONE, 8'hFF);
	endtask

	// a bad sum check on an empty frame
	task automatic test_bad_checks();
		send_frame(8'h5A, 8'hA5, 8'd0, DMG_SUM);
	endtask

	// store boundary, too long frame and mismatch precedence over too long,
	// run as one long stretch with no idling on either side
	task automatic test_store_limits();
		calm = 1'b1;
		send_frame(8'($urandom), 8'($urandom), 8'(StoreDepth), DMG_NONE, 8'h00);
		send_frame(8'($urandom), 8'($urandom), 8'(StoreDepth + 1), DMG_NONE);
		send_frame(8'($urandom), 8'($urandom), 8'(StoreDepth + 1), DMG_ADD);
		calm = 1'b0;
	endtask

	// sender holds off between frames until the output is empty
	task automatic test_drain_pause();
		send_frame(8'($urandom), 8'($urandom), 8'd1, DMG_NONE);
		wait_drained();
		send_frame(8'($urandom), 8'($urandom), 8'd0, DMG_NONE);
		wait_drained();
	endtask

	// short frames with random content, plus noise, cut and broken frames
	task automatic test_random_frames();
		int start_bytes;
		int pick;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 24) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_rx_byte(8'($urandom));
			end else if (pick < 16) begin
				send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)), DMG_NONE,
					-1, $urandom_range(1, 6));
			end else if (pick < 32) begin
				send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)),
					2'($urandom_range(1, 3)));
			end else begin
				send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 6)), DMG_NONE);
			end
			if ($urandom_range(9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hunt_noise();
		test_empty_frame();
		test_single_byte();
		test_bad_checks();
		test_store_limits();
		test_drain_pause();
		test_random_frames();
		wait_drained();
		repeat (60) @(posedge clk);
		if (frames_due.size() != 0)
			note_failure($sformatf("%0d results never arrived", frames_due.size()));
		$display("covered %0d bytes, %0d of %0d predicted results checked",
			bytes_sent, results_checked, results_due_total);
		$display("frames: %0d good, %0d check mismatch, %0d too long, %0d mismatches",
			good_frames, bad_frames, long_frames, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", frames_due.size());
		$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sacfr_pkg.sv
hdl/sacfr_front.sv
hdl/sacfr_queue.sv
hdl/sacfr_back.sv
hdl/sum_add_checked_frame_receiver.sv
dv/sum_add_checked_frame_receiver_test.sv
